// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the nibble sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define CLNS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clns assertion failed");

// Next-cycle implication, disabled while in reset.
`define CLNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clns assertion failed");

`endif

// ===== rtl/clns_pkg.sv =====
// Types, constants and job tables for the character-LCD nibble sequencer.
package clns_pkg;

	localparam int CLNS_QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic [1:0] REG_RS_BIT   = 2'd0;
	localparam logic [1:0] REG_EN_BIT   = 2'd1;
	localparam logic [1:0] REG_DEV_ADDR = 2'd2;

	localparam logic [1:0] RST_RS_BIT   = 2'd0;
	localparam logic [2:0] RST_EN_BIT   = 3'd2;
	localparam logic [6:0] RST_DEV_ADDR = 7'd39;

	// delays in microseconds
	localparam logic [14:0] DLY_POWER_ON      = 15'd20000;
	localparam logic [14:0] DLY_RESET2        = 15'd5001;
	localparam logic [14:0] DLY_RESET3        = 15'd151;
	localparam logic [14:0] DLY_STROBE_BEFORE = 15'd1;
	localparam logic [10:0] DLY_STROBE_AFTER  = 11'd1;
	localparam logic [10:0] DLY_SETTLE        = 11'd45;
	localparam logic [10:0] DLY_CLEAR         = 11'd2045;

	localparam logic [7:0] HI_MASK   = 8'hF0;
	localparam logic [7:0] LO_MASK   = 8'h0F;
	localparam logic [7:0] NIB_ZERO  = 8'h00;
	localparam logic [7:0] NIB_RESET = 8'h30;
	localparam logic [7:0] NIB_4BIT  = 8'h20;
	localparam logic [7:0] CMD_SLOW_LIMIT = 8'h04;

	localparam logic [7:0] CMD_FUNC_SET = 8'h28;
	localparam logic [7:0] CMD_DISP_OFF = 8'h08;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
	localparam logic [7:0] CMD_HOME_DD  = 8'h80;

	localparam logic [1:0] PART_RS    = 2'd0;
	localparam logic [1:0] PART_HI    = 2'd1;
	localparam logic [1:0] PART_LAST  = 2'd2;
	localparam logic [2:0] PRE_LAST   = 3'd4;
	localparam logic [2:0] CMD_LAST   = 3'd4;

	typedef enum logic [1:0] {
		JOB_RS_FIX    = 2'd0,
		JOB_NIB_PULSE = 2'd1,
		JOB_PULSE     = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic        is_data;
		logic [7:0]  nib;
		logic [14:0] nib_before;
		logic [14:0] en_before;
		logic [10:0] after;
		logic        last;
	} job_t;

	typedef struct packed {
		logic [1:0] rs_bit;
		logic [2:0] en_bit;
		logic [6:0] device_address;
	} cfg_t;

	// one of the three jobs that send a byte
	function automatic job_t byte_job(input logic [7:0] code, input logic data,
			input logic [1:0] part, input logic [1:0] rs_bit);
		job_t j;
		logic [7:0] rsn;
		rsn = data ? ((8'h01 << rs_bit) & LO_MASK) : 8'h00;
		j = '0;
		case (part)
			PART_RS: begin
				j.kind    = JOB_RS_FIX;
				j.is_data = data;
			end
			PART_HI: begin
				j.kind      = JOB_NIB_PULSE;
				j.nib       = (code & HI_MASK) | rsn;
				j.en_before = DLY_STROBE_BEFORE;
				j.after     = DLY_SETTLE;
			end
			default: begin
				j.kind      = JOB_NIB_PULSE;
				j.nib       = {code[3:0], 4'h0} | rsn;
				j.en_before = DLY_STROBE_BEFORE;
				j.after     = (!data && code < CMD_SLOW_LIMIT) ? DLY_CLEAR : DLY_SETTLE;
			end
		endcase
		return j;
	endfunction

	// power-up preamble: reset nibbles and the switch to 4-bit mode
	function automatic job_t pre_job(input logic [2:0] idx);
		job_t j;
		j = '0;
		j.kind      = JOB_NIB_PULSE;
		j.en_before = DLY_STROBE_BEFORE;
		j.after     = DLY_SETTLE;
		case (idx)
			3'd0: begin
				j.nib        = NIB_ZERO;
				j.nib_before = DLY_POWER_ON;
			end
			3'd1: j.nib = NIB_RESET;
			3'd2: begin
				j.kind      = JOB_PULSE;
				j.en_before = DLY_RESET2;
			end
			3'd3: begin
				j.kind      = JOB_PULSE;
				j.en_before = DLY_RESET3;
			end
			default: j.nib = NIB_4BIT;
		endcase
		return j;
	endfunction

	function automatic logic [7:0] init_code(input logic [2:0] idx);
		case (idx)
			3'd0:    return CMD_FUNC_SET;
			3'd1:    return CMD_DISP_OFF;
			3'd2:    return CMD_CLEAR;
			3'd3:    return CMD_DISP_ON;
			default: return CMD_HOME_DD;
		endcase
	endfunction

endpackage

// ===== rtl/clns_ifs.sv =====
// Valid/ready channel interfaces for LCD requests and expander writes.
interface clns_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] code_byte;
	logic       is_data;

	modport source (output valid, action, code_byte, is_data, input ready);
	modport sink   (input valid, action, code_byte, is_data, output ready);
endinterface

interface clns_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  expander_byte;
	logic [6:0]  bus_address;
	logic [14:0] delay_before_us;
	logic [10:0] delay_after_us;
	logic        last_of_run;

	modport source (output valid, expander_byte, bus_address, delay_before_us,
		delay_after_us, last_of_run, input ready);
	modport sink   (input valid, expander_byte, bus_address, delay_before_us,
		delay_after_us, last_of_run, output ready);
endinterface

// ===== rtl/char_lcd_nibble_sequencer.sv =====
// Character-LCD nibble sequencer top: HD44780 4-bit writes through an I2C port expander.
//
// req (sink): one beat is either a byte for the display (action 0, code_byte, is_data)
// or a power-up request (action 1). rsp (source): one beat per expander write, with the
// expander byte, bus address, delays before and after, and last_of_run on the final one.
// A byte gives 7 beats, a power-up 48. The APB port sets rs_bit, en_bit and
// device_address at byte addresses 0, 4 and 8; only write it while the block is idle.
// The front end takes a request when it is idle and splits it into jobs (3 for a byte,
// 20 for power-up) into a job queue, one job a cycle while the queue has room; the back
// end turns each job into 1 to 3 beats, one beat a cycle while rsp is not stalled, into a
// registered output stage. The first beat passes the front-end state register, the queue
// and the back-end job register before the output register. With rsp never stalled the
// beats of a byte or of a power-up leave back to back. A stalled rsp holds the beat and
// backs up the queue, then the front end; the next request is taken once its previous
// jobs are all in the queue.
// Reset clears the registers to their defaults, empties the queue and clears the
// stored expander value to zero.
module char_lcd_nibble_sequencer
	import clns_pkg::*;
#(
	parameter int QueueDepth = CLNS_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	clns_req_if.sink    req,
	clns_rsp_if.source  rsp
);

	cfg_t       cfg_q;
	logic       push_valid;
	job_t       push_job;
	logic       push_ready;
	logic       pop_valid;
	job_t       pop_job;
	logic       pop_ready;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rs_bit         <= RST_RS_BIT;
			cfg_q.en_bit         <= RST_EN_BIT;
			cfg_q.device_address <= RST_DEV_ADDR;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_RS_BIT:   cfg_q.rs_bit         <= pwdata[1:0];
				REG_EN_BIT:   cfg_q.en_bit         <= pwdata[2:0];
				REG_DEV_ADDR: cfg_q.device_address <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RS_BIT:   prdata = 32'(cfg_q.rs_bit);
			REG_EN_BIT:   prdata = 32'(cfg_q.en_bit);
			REG_DEV_ADDR: prdata = 32'(cfg_q.device_address);
			default:      prdata = '0;
		endcase
	end

	clns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.req        (req),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	clns_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	clns_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_job   (pop_job),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule

// ===== rtl/clns_front.sv =====
// Front end: accepts requests and breaks them into nibble jobs.
module clns_front
	import clns_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	clns_req_if.sink   req,
	output logic       push_valid,
	output job_t       push_job,
	input  logic       push_ready
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_BYTE = 4'b0010,
		S_PRE  = 4'b0100,
		S_CMD  = 4'b1000
	} front_state_t;

	front_state_t state_q;
	logic [1:0]   part_q;
	logic [2:0]   idx_q;
	logic [7:0]   code_q;
	logic         data_q;
	logic         push_fire;

	assign req.ready  = (state_q == S_IDLE);
	assign push_valid = (state_q != S_IDLE);
	assign push_fire  = push_valid && push_ready;

	always_comb begin
		case (state_q)
			S_BYTE: begin
				push_job      = byte_job(code_q, data_q, part_q, cfg.rs_bit);
				push_job.last = (part_q == PART_LAST);
			end
			S_PRE: begin
				push_job = pre_job(idx_q);
			end
			S_CMD: begin
				push_job      = byte_job(init_code(idx_q), 1'b0, part_q, cfg.rs_bit);
				push_job.last = (part_q == PART_LAST) && (idx_q == CMD_LAST);
			end
			default: begin
				push_job = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			code_q <= req.code_byte;
			data_q <= req.is_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			part_q  <= 2'd0;
			idx_q   <= 3'd0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= req.action ? S_PRE : S_BYTE;
					end
				end
				S_BYTE: begin
					if (push_fire) begin
						if (part_q == PART_LAST) begin
							part_q  <= 2'd0;
							state_q <= S_IDLE;
						end else begin
							part_q <= part_q + 2'd1;
						end
					end
				end
				S_PRE: begin
					if (push_fire) begin
						if (idx_q == PRE_LAST) begin
							idx_q   <= 3'd0;
							state_q <= S_CMD;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				S_CMD: begin
					if (push_fire) begin
						if (part_q == PART_LAST) begin
							part_q <= 2'd0;
							if (idx_q == CMD_LAST) begin
								idx_q   <= 3'd0;
								state_q <= S_IDLE;
							end else begin
								idx_q <= idx_q + 3'd1;
							end
						end else begin
							part_q <= part_q + 2'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/clns_queue.sv =====
// Small job queue between the front end and the beat generator.
`include "assert_macros.svh"

module clns_queue
	import clns_pkg::*;
#(
	parameter int Depth = CLNS_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  job_t push_job,
	output logic push_ready,
	output logic pop_valid,
	output job_t pop_job,
	input  logic pop_ready
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t            slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            push_fire;
	logic            pop_fire;

	assign push_ready = (cnt_q != CntW'(Depth));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push_fire && !pop_fire) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop_fire && !push_fire) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	`CLNS_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CntW'(Depth))
	`CLNS_ASSERT_NEXT(a_cnt_grow, clk, arst_n, push_fire && !pop_fire, cnt_q == $past(cnt_q) + CntW'(1))

endmodule

// ===== rtl/clns_back.sv =====
// Back end: plays each job out as expander write beats into an output register.
`include "assert_macros.svh"

module clns_back
	import clns_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      pop_valid,
	input  job_t      pop_job,
	output logic      pop_ready,
	clns_rsp_if.source rsp
);

	job_t        cur_q;
	logic        active_q;
	logic [1:0]  beat_q;
	logic [7:0]  lev_q;

	logic        ov_q;
	logic [7:0]  obyte_q;
	logic [6:0]  oaddr_q;
	logic [14:0] obefore_q;
	logic [10:0] oafter_q;
	logic        olast_q;

	logic [7:0]  rs_mask;
	logic [7:0]  en_mask;
	logic        adv;
	logic        final_beat;
	logic        pop_fire;
	logic [7:0]  beat_byte;
	logic [14:0] beat_before;
	logic [10:0] beat_after;

	assign rs_mask    = 8'h01 << cfg.rs_bit;
	assign en_mask    = 8'h01 << cfg.en_bit;
	assign adv        = active_q && (!ov_q || rsp.ready);
	assign final_beat = (cur_q.kind == JOB_RS_FIX) || (beat_q == 2'd2);
	assign pop_ready  = !active_q || (adv && final_beat);
	assign pop_fire   = pop_valid && pop_ready;

	// beat 0 writes the nibble (or the RS fix-up), beats 1 and 2 are the strobe
	always_comb begin
		case (beat_q)
			2'd0: begin
				if (cur_q.kind == JOB_RS_FIX) begin
					beat_byte   = cur_q.is_data ? (lev_q | rs_mask) : (lev_q & ~rs_mask);
					beat_before = '0;
				end else begin
					beat_byte   = cur_q.nib;
					beat_before = cur_q.nib_before;
				end
				beat_after = '0;
			end
			2'd1: begin
				beat_byte   = lev_q | en_mask;
				beat_before = cur_q.en_before;
				beat_after  = DLY_STROBE_AFTER;
			end
			default: begin
				beat_byte   = lev_q & ~en_mask;
				beat_before = '0;
				beat_after  = cur_q.after;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop_fire) begin
			cur_q <= pop_job;
		end
		if (adv) begin
			obyte_q   <= beat_byte;
			oaddr_q   <= cfg.device_address;
			obefore_q <= beat_before;
			oafter_q  <= beat_after;
			olast_q   <= final_beat && cur_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			beat_q   <= 2'd0;
			lev_q    <= 8'h00;
			ov_q     <= 1'b0;
		end else begin
			if (pop_fire) begin
				active_q <= 1'b1;
				beat_q   <= (pop_job.kind == JOB_PULSE) ? 2'd1 : 2'd0;
			end else if (adv) begin
				if (final_beat) begin
					active_q <= 1'b0;
				end else begin
					beat_q <= beat_q + 2'd1;
				end
			end
			if (adv && beat_q == 2'd0 && cur_q.kind == JOB_NIB_PULSE) begin
				lev_q <= cur_q.nib;
			end
			if (adv) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.expander_byte   = obyte_q;
	assign rsp.bus_address     = oaddr_q;
	assign rsp.delay_before_us = obefore_q;
	assign rsp.delay_after_us  = oafter_q;
	assign rsp.last_of_run     = olast_q;

	`CLNS_ASSERT_IMPL(a_beat_range, clk, arst_n, active_q, beat_q != 2'd3)
	`CLNS_ASSERT_NEXT(a_last_flag, clk, arst_n, adv && final_beat && cur_q.last, rsp.valid && rsp.last_of_run)

endmodule
